### src/nof_pkg.sv
// Package for the MIDI note octave fold block: payload structs, message kind codes,
// queue entry and control structs shared by the front, back and top level.
// Depends on nothing.
package nof_pkg;

  localparam int unsigned NUM_NOTES    = 128;
  localparam int unsigned NUM_CHANNELS = 16;
  localparam int unsigned MAP_DEPTH    = NUM_NOTES * NUM_CHANNELS;
  localparam int unsigned MAP_AW       = $clog2(MAP_DEPTH);
  localparam int unsigned CHAN_BITS    = $clog2(NUM_CHANNELS);

  // Upper nibble of the status byte.
  localparam logic [3:0] KIND_NOTE_OFF      = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON       = 4'h9;
  localparam logic [3:0] KIND_POLY_PRESSURE = 4'hA;

  // Listen channel code meaning every channel (-1 in five bits).
  localparam logic [4:0] LISTEN_ALL = 5'h1F;

  // One octave in note steps.
  localparam logic signed [8:0] OCTAVE = 9'sd12;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LOW_NOTE  = 2'd0,
    REG_HIGH_NOTE = 2'd1,
    REG_LISTEN    = 2'd2
  } nof_reg_e;

  // What the back end has to do with a queued message.
  typedef enum logic [1:0] {
    OP_PASS,
    OP_FOLD_ON,
    OP_FOLD_PP,
    OP_NOTE_OFF
  } nof_op_e;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] note_byte;
    logic [6:0] value_byte;
  } nof_in_t;

  typedef struct packed {
    logic [7:0] out_status;
    logic [7:0] out_note;
    logic [6:0] out_value;
  } nof_out_t;

  typedef struct packed {
    nof_in_t msg;
    nof_op_e op;
  } nof_entry_t;

  typedef struct packed {
    logic [6:0] low_note;
    logic [6:0] high_note;
    logic [4:0] listen_channel;
  } nof_cfg_t;

  // Control from the back end towards the front end.
  typedef struct packed {
    logic clearing;
    logic pop;
  } nof_ctl_t;

endpackage

### src/midi_note_octave_fold.sv
// Top level of the MIDI note octave fold block: configuration registers, front and
// back ends and checks. Depends on nof_pkg, nof_front and nof_back.
//
// Each accepted three-byte message is classified on entry and queued; the back end then
// handles one message at a time. After reset the note map is set to identity in a pass
// over all 2048 entries, during which no message is accepted (configuration writes still
// are). In the back end a pass-through message goes from idle straight to the emit state,
// a note-off first reads the map and then writes it back, and a note-on or poly pressure
// takes k octave steps, where k is 0 to 11, since the stepping unit moves one octave
// per cycle; a dropped message skips the emit state. The queue lets input be taken while
// the back end works and while a finished result waits in the output register.
module midi_note_octave_fold #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  nof_pkg::nof_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output nof_pkg::nof_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  nof_pkg::nof_cfg_t   cfg_q, cfg_d;
  nof_pkg::nof_ctl_t   ctl;
  nof_pkg::nof_entry_t head;
  nof_pkg::nof_reg_e   reg_idx;
  logic                head_valid;
  logic                cfg_we;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = nof_pkg::nof_reg_e'(paddr[3:2]);

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (reg_idx)
        nof_pkg::REG_LOW_NOTE:  cfg_d.low_note       = pwdata[6:0];
        nof_pkg::REG_HIGH_NOTE: cfg_d.high_note      = pwdata[6:0];
        nof_pkg::REG_LISTEN:    cfg_d.listen_channel = pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      nof_pkg::REG_LOW_NOTE:  prdata = {25'd0, cfg_q.low_note};
      nof_pkg::REG_HIGH_NOTE: prdata = {25'd0, cfg_q.high_note};
      nof_pkg::REG_LISTEN:    prdata = {27'd0, cfg_q.listen_channel};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{low_note: 7'd0, high_note: 7'd127, listen_channel: nof_pkg::LISTEN_ALL};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  nof_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_data_i        (in_data_i),
    .listen_channel_i (cfg_q.listen_channel),
    .ctl_i            (ctl),
    .head_valid_o     (head_valid),
    .head_o           (head)
  );

  nof_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .ctl_o        (ctl),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // No message may enter while the map is still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctl.clearing |-> in_stall_o)
    else $error("input accepted during map clearing");

  // No result can exist before the clearing pass has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctl.clearing |-> !out_valid_o)
    else $error("result shown during map clearing");

  // The back end only takes a message that the queue holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctl.pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

### src/nof_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module nof_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### src/nof_front.sv
// Front end: classifies each incoming message and holds it in a short queue.
// Depends on nof_pkg.
module nof_front #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  nof_pkg::nof_in_t    in_data_i,
  input  logic [4:0]          listen_channel_i,
  input  nof_pkg::nof_ctl_t   ctl_i,
  output logic                head_valid_o,
  output nof_pkg::nof_entry_t head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  nof_pkg::nof_entry_t entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  logic [3:0] kind, chan;
  logic       is_on, is_off, is_pp, match;
  logic       push;
  nof_pkg::nof_op_e op;

  // Classify the message; a zero-velocity note-on counts as a note-off.
  always_comb begin
    kind   = in_data_i.status_byte[7:4];
    chan   = in_data_i.status_byte[3:0];
    is_on  = (kind == nof_pkg::KIND_NOTE_ON) && (in_data_i.value_byte != 7'd0);
    is_off = (kind == nof_pkg::KIND_NOTE_OFF) ||
             ((kind == nof_pkg::KIND_NOTE_ON) && (in_data_i.value_byte == 7'd0));
    is_pp  = (kind == nof_pkg::KIND_POLY_PRESSURE);
    match  = (listen_channel_i == nof_pkg::LISTEN_ALL) ||
             (!listen_channel_i[4] && (listen_channel_i[3:0] == chan));
    if (!match) begin
      op = nof_pkg::OP_PASS;
    end else if (is_on) begin
      op = nof_pkg::OP_FOLD_ON;
    end else if (is_pp) begin
      op = nof_pkg::OP_FOLD_PP;
    end else if (is_off) begin
      op = nof_pkg::OP_NOTE_OFF;
    end else begin
      op = nof_pkg::OP_PASS;
    end
  end

  // Input is held off while the queue is full or the map is being cleared.
  assign in_stall_o   = (count_q == CntW'(QueueDepth)) || ctl_i.clearing;
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (ctl_i.pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !ctl_i.pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push && ctl_i.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{msg: in_data_i, op: op};
    end
  end

endmodule

### src/nof_back.sv
// Back end: octave stepping, note map read-modify-write and the output register.
// Depends on nof_pkg and nof_ram.
module nof_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nof_pkg::nof_cfg_t   cfg_i,
  input  logic                head_valid_i,
  input  nof_pkg::nof_entry_t head_i,
  output nof_pkg::nof_ctl_t   ctl_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nof_pkg::nof_out_t   out_data_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FOLD,
    S_OFF,
    S_EMIT
  } state_e;

  state_e                        state_q, state_d;
  nof_pkg::nof_entry_t           ent_q, ent_d;
  logic signed [8:0]             nn_q, nn_d;
  logic                          up_q, up_d, dn_q, dn_d;
  logic [7:0]                    note_out_q, note_out_d;
  logic [nof_pkg::MAP_AW-1:0]    clr_q, clr_d;
  logic                          out_valid_q, out_valid_d;
  nof_pkg::nof_out_t             out_data_q, out_data_d;

  logic                          we, re, pop;
  logic [nof_pkg::MAP_AW-1:0]    waddr, raddr, ent_idx;
  logic [7:0]                    wdata, rdata;
  logic signed [8:0]             lo_s, hi_s;
  logic                          out_free;

  assign lo_s     = $signed({2'b00, cfg_i.low_note});
  assign hi_s     = $signed({2'b00, cfg_i.high_note});
  assign ent_idx  = {ent_q.msg.note_byte, ent_q.msg.status_byte[3:0]};
  assign raddr    = {head_i.msg.note_byte, head_i.msg.status_byte[3:0]};
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer: one octave step per cycle, map accesses, result hand-off.
  always_comb begin
    state_d     = state_q;
    ent_d       = ent_q;
    nn_d        = nn_q;
    up_d        = up_q;
    dn_d        = dn_q;
    note_out_d  = note_out_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    we          = 1'b0;
    waddr       = ent_idx;
    wdata       = nn_q[7:0];
    re          = 1'b0;
    pop         = 1'b0;
    case (state_q)
      S_CLEAR: begin
        // Every entry is set to its own note after reset.
        we    = 1'b1;
        waddr = clr_q;
        wdata = 8'(clr_q >> nof_pkg::CHAN_BITS);
        clr_d = clr_q + nof_pkg::MAP_AW'(1);
        if (clr_q == nof_pkg::MAP_AW'(nof_pkg::MAP_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid_i) begin
          pop        = 1'b1;
          ent_d      = head_i;
          note_out_d = {1'b0, head_i.msg.note_byte};
          nn_d       = $signed({2'b00, head_i.msg.note_byte});
          up_d       = head_i.msg.note_byte < cfg_i.low_note;
          dn_d       = !(head_i.msg.note_byte < cfg_i.low_note) &&
                       (head_i.msg.note_byte > cfg_i.high_note);
          case (head_i.op)
            nof_pkg::OP_FOLD_ON,
            nof_pkg::OP_FOLD_PP: state_d = S_FOLD;
            nof_pkg::OP_NOTE_OFF: begin
              re      = 1'b1;
              state_d = S_OFF;
            end
            default: state_d = S_EMIT;
          endcase
        end
      end
      S_FOLD: begin
        if (up_q && (nn_q < lo_s)) begin
          nn_d = nn_q + nof_pkg::OCTAVE;
        end else if (dn_q && (nn_q > hi_s)) begin
          nn_d = nn_q - nof_pkg::OCTAVE;
        end else begin
          // Folding done: a note-on records its result even when it is dropped.
          note_out_d = nn_q[7:0];
          we         = (ent_q.op == nof_pkg::OP_FOLD_ON);
          if ((up_q && (nn_q > hi_s)) || (dn_q && (nn_q < lo_s))) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_OFF: begin
        // Map data has arrived; the entry goes back to identity.
        note_out_d = rdata;
        we         = 1'b1;
        wdata      = {1'b0, ent_q.msg.note_byte};
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{out_status: ent_q.msg.status_byte,
                          out_note:   note_out_q,
                          out_value:  ent_q.msg.value_byte};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ent_q       <= '0;
      nn_q        <= '0;
      up_q        <= 1'b0;
      dn_q        <= 1'b0;
      note_out_q  <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      ent_q       <= ent_d;
      nn_q        <= nn_d;
      up_q        <= up_d;
      dn_q        <= dn_d;
      note_out_q  <= note_out_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  nof_ram #(
    .Width (8),
    .Depth (nof_pkg::MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ctl_o       = '{clearing: (state_q == S_CLEAR), pop: pop};
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### sim/midi_note_octave_fold_test.sv
// Self-checking testbench for midi_note_octave_fold: drives MIDI messages and
// register writes, predicts each output message and compares it field by field.
// Depends on nof_pkg and the midi_note_octave_fold top level.
`timescale 1ns / 1ps

module midi_note_octave_fold_test;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned PRINT_CAP     = 200;

  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic              in_valid = 1'b0;
  nof_pkg::nof_in_t  in_data  = '0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall = 1'b0;
  nof_pkg::nof_out_t out_data;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [3:0]        paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Predictor copy of the registers and of the note map.
  logic [6:0] low_cfg    = 7'd0;
  logic [6:0] high_cfg   = 7'd127;
  logic [4:0] listen_cfg = nof_pkg::LISTEN_ALL;
  logic [7:0] note_map [nof_pkg::MAP_DEPTH];

  nof_pkg::nof_in_t  pending_msgs [$];
  nof_pkg::nof_out_t expected_msgs [$];
  logic [10:0]       sounding_notes [$];
  nof_pkg::nof_out_t predicted;
  nof_pkg::nof_out_t oldest;

  int unsigned cycle_count     = 0;
  int          error_count     = 0;
  int          msgs_in         = 0;
  int          msgs_out        = 0;
  int          msgs_dropped    = 0;
  int          reg_writes      = 0;
  int          in_stall_cycles = 0;
  int          gap_left        = 0;
  int          stall_left      = 0;
  int          hold_left       = 0;
  int          hold_requests   = 0;
  int          hold_taken      = 0;
  bit          no_idle         = 1'b0;

  midi_note_octave_fold uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Works out the output for one message and updates the note map. Returns 0 when
  // the message is dropped because folding overshot the range.
  function automatic bit fold_and_map(input nof_pkg::nof_in_t m, output nof_pkg::nof_out_t r);
    logic [3:0]  kind;
    logic [3:0]  chan;
    logic [10:0] idx;
    int          nn;
    int          lo;
    int          hi;
    bit          dropped;
    kind    = m.status_byte[7:4];
    chan    = m.status_byte[3:0];
    idx     = {m.note_byte, chan};
    nn      = int'(m.note_byte);
    lo      = int'(low_cfg);
    hi      = int'(high_cfg);
    dropped = 1'b0;
    r.out_status = m.status_byte;
    r.out_note   = {1'b0, m.note_byte};
    r.out_value  = m.value_byte;
    // A note-on with zero velocity is a note-off.
    if (kind == nof_pkg::KIND_NOTE_ON && m.value_byte == '0) kind = nof_pkg::KIND_NOTE_OFF;
    if (listen_cfg == nof_pkg::LISTEN_ALL ||
        (!listen_cfg[4] && listen_cfg[3:0] == chan)) begin
      if (kind == nof_pkg::KIND_NOTE_ON || kind == nof_pkg::KIND_POLY_PRESSURE) begin
        // Step by octaves towards the range; each direction stops past its bound.
        if (nn < lo) begin
          while (nn < lo) nn += int'(nof_pkg::OCTAVE);
          dropped = (nn > hi);
        end else if (nn > hi) begin
          while (nn > hi) nn -= int'(nof_pkg::OCTAVE);
          dropped = (nn < lo);
        end
        r.out_note = nn[7:0];
        if (kind == nof_pkg::KIND_NOTE_ON) note_map[idx] = nn[7:0];
      end else if (kind == nof_pkg::KIND_NOTE_OFF) begin
        r.out_note    = note_map[idx];
        note_map[idx] = {1'b0, m.note_byte};
      end
    end
    return !dropped;
  endfunction

  // Input driver: predicts on each transfer, then offers the next message or idles.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        msgs_in++;
        if (fold_and_map(in_data, predicted)) expected_msgs.insert(expected_msgs.size(), predicted);
        else msgs_dropped++;
      end
      if (in_valid && in_stall) in_stall_cycles++;
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_msgs.size() != 0) begin
          in_data  <= pending_msgs.pop_front();
          in_valid <= 1'b1;
          if (!no_idle && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each transfer against the oldest prediction, then
  // decides the stall for the next cycle.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_msgs.size() == 0) begin
          report_mismatch($sformatf("unexpected message %h", out_data));
        end else begin
          oldest = expected_msgs.pop_front();
          msgs_out++;
          if (out_data.out_status !== oldest.out_status)
            report_mismatch($sformatf("status got %h want %h",
                                      out_data.out_status, oldest.out_status));
          if (out_data.out_note !== oldest.out_note)
            report_mismatch($sformatf("note got %h want %h",
                                      out_data.out_note, oldest.out_note));
          if (out_data.out_value !== oldest.out_value)
            report_mismatch($sformatf("value got %h want %h",
                                      out_data.out_value, oldest.out_value));
        end
      end
      if (hold_taken != hold_requests) begin
        hold_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Register write: setup cycle, then access cycle until pready, then read-back.
  task automatic write_reg(input nof_pkg::nof_reg_e which, input logic [6:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (which)
      nof_pkg::REG_LOW_NOTE:  low_cfg  = value;
      nof_pkg::REG_HIGH_NOTE: high_cfg = value;
      default:                listen_cfg = value[4:0];
    endcase
    reg_writes++;
    @(posedge clk);
    if (prdata !== ((which == nof_pkg::REG_LISTEN) ? {27'd0, value[4:0]} : {25'd0, value}))
      report_mismatch($sformatf("register %0d reads %h", which, prdata));
  endtask

  task automatic set_config(input logic [6:0] lo, input logic [6:0] hi,
                            input logic [4:0] listen);
    write_reg(nof_pkg::REG_LOW_NOTE, lo);
    write_reg(nof_pkg::REG_HIGH_NOTE, hi);
    write_reg(nof_pkg::REG_LISTEN, {2'b00, listen});
  endtask

  // Waits until every message is through, then lets a dropped one finish.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_msgs.size() != 0 || in_valid || expected_msgs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void queue_message(input logic [7:0] s, input logic [6:0] n,
                                        input logic [6:0] v);
    nof_pkg::nof_in_t m;
    m = '{status_byte: s, note_byte: n, value_byte: v};
    pending_msgs.insert(pending_msgs.size(), m);
  endfunction

  // Mostly note-on / note-off pairs on sounding notes, some pressure and noise.
  function automatic nof_pkg::nof_in_t random_message();
    nof_pkg::nof_in_t m;
    int               pick;
    int               slot;
    logic [3:0]       chan;
    pick = $urandom_range(0, 99);
    chan = 4'($urandom_range(0, 15));
    if (!listen_cfg[4] && $urandom_range(0, 3) != 0) chan = listen_cfg[3:0];
    m.note_byte  = 7'($urandom_range(0, 127));
    m.value_byte = 7'($urandom_range(0, 127));
    if (pick < 35) begin
      m.status_byte = {nof_pkg::KIND_NOTE_ON, chan};
      if ($urandom_range(0, 9) == 0) begin
        m.value_byte = '0;
      end else begin
        if (m.value_byte == '0) m.value_byte = 7'd1;
        sounding_notes.insert(sounding_notes.size(), {m.note_byte, chan});
      end
    end else if (pick < 60) begin
      m.status_byte = {nof_pkg::KIND_NOTE_OFF, chan};
      if (sounding_notes.size() != 0) begin
        slot = $urandom_range(0, sounding_notes.size() - 1);
        {m.note_byte, m.status_byte[3:0]} = sounding_notes[slot];
        sounding_notes.delete(slot);
      end
    end else if (pick < 75) begin
      m.status_byte = {nof_pkg::KIND_POLY_PRESSURE, chan};
    end else begin
      m.status_byte = 8'($urandom_range(0, 255));
    end
    return m;
  endfunction

  // Stimulus sequence and end of run.
  initial begin
    int lo;
    int hi;
    for (int n = 0; n < nof_pkg::NUM_NOTES; n++) begin
      for (int c = 0; c < nof_pkg::NUM_CHANNELS; c++) note_map[{7'(n), 4'(c)}] = 8'(n);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: non-status bytes, plain notes, zero-velocity note-on, other kinds.
    queue_message(8'h00, 7'd0, 7'd0);
    queue_message(8'h7F, 7'd127, 7'd127);
    queue_message({nof_pkg::KIND_NOTE_ON, 4'd0}, 7'd60, 7'd100);
    queue_message({nof_pkg::KIND_NOTE_OFF, 4'd0}, 7'd60, 7'd0);
    queue_message({nof_pkg::KIND_NOTE_ON, 4'd15}, 7'd127, 7'd0);
    queue_message({nof_pkg::KIND_POLY_PRESSURE, 4'd15}, 7'd127, 7'd127);
    queue_message(8'hB3, 7'd7, 7'd64);
    queue_message(8'hFF, 7'd85, 7'd42);
    wait_idle();

    // One octave window on one channel: folding up and down, remapped note-offs.
    set_config(7'd48, 7'd59, 5'd3);
    queue_message({nof_pkg::KIND_NOTE_ON, 4'd3}, 7'd0, 7'd1);
    queue_message({nof_pkg::KIND_NOTE_ON, 4'd3}, 7'd127, 7'd127);
    queue_message({nof_pkg::KIND_POLY_PRESSURE, 4'd3}, 7'd20, 7'd33);
    queue_message({nof_pkg::KIND_NOTE_OFF, 4'd3}, 7'd0, 7'd0);
    queue_message({nof_pkg::KIND_NOTE_OFF, 4'd3}, 7'd127, 7'd64);
    queue_message({nof_pkg::KIND_NOTE_ON, 4'd4}, 7'd0, 7'd5);
    wait_idle();

    // Upward overshoot past the top note; the note-off returns the overshot byte.
    set_config(7'd127, 7'd127, nof_pkg::LISTEN_ALL);
    queue_message({nof_pkg::KIND_NOTE_ON, 4'd1}, 7'd6, 7'd3);
    queue_message({nof_pkg::KIND_NOTE_OFF, 4'd1}, 7'd6, 7'd0);
    queue_message({nof_pkg::KIND_POLY_PRESSURE, 4'd0}, 7'd0, 7'd1);
    wait_idle();

    // Downward overshoot below zero wraps to a high byte.
    set_config(7'd0, 7'd0, nof_pkg::LISTEN_ALL);
    queue_message({nof_pkg::KIND_NOTE_ON, 4'd2}, 7'd10, 7'd9);
    queue_message({nof_pkg::KIND_NOTE_ON, 4'd2}, 7'd10, 7'd0);
    wait_idle();

    // Low bound above high bound: every fold is dropped but still recorded.
    set_config(7'd100, 7'd20, 5'd15);
    queue_message({nof_pkg::KIND_NOTE_ON, 4'd15}, 7'd50, 7'd1);
    queue_message({nof_pkg::KIND_NOTE_OFF, 4'd15}, 7'd50, 7'd2);
    queue_message({nof_pkg::KIND_NOTE_ON, 4'd14}, 7'd50, 7'd3);
    wait_idle();

    // A negative listen channel other than all matches nothing.
    set_config(7'd0, 7'd127, 5'h10);
    queue_message({nof_pkg::KIND_NOTE_ON, 4'd0}, 7'd5, 7'd5);
    queue_message({nof_pkg::KIND_NOTE_OFF, 4'd0}, 7'd5, 7'd5);

    // Random phases, each under its own settings; the last one runs without idling.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      lo = $urandom_range(0, 127);
      hi = $urandom_range(lo, 127);
      case (phase)
        0: set_config(7'd0, 7'd127, nof_pkg::LISTEN_ALL);
        1: set_config(7'd127, 7'd0, 5'($urandom_range(0, 15)));
        3: set_config(7'(lo), 7'(lo), 5'($urandom_range(0, 15)));
        4: set_config(7'(lo), 7'(hi), 5'($urandom_range(16, 30)));
        default: set_config(7'(lo), 7'(hi), ($urandom_range(0, 2) == 0) ?
                                    5'($urandom_range(0, 15)) : nof_pkg::LISTEN_ALL);
      endcase
      no_idle = (phase == NUM_PHASES - 1);
      if (phase == 2) hold_requests++;
      for (int k = 0; k < PHASE_ITEMS; k++)
        pending_msgs.insert(pending_msgs.size(), random_message());
    end
    wait_idle();

    $display("Ran %0d messages through %0d register writes: %0d returned, %0d dropped.",
             msgs_in, reg_writes, msgs_out, msgs_dropped);
    $display("Input was held back for %0d cycles; %0d mismatches seen.",
             in_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
